// ----- hdl/dds_register_word_formatter_unit_defines.svh -----
// Assertion macros used by the DDS register word formatter back end.
`ifndef DDS_REGISTER_WORD_FORMATTER_UNIT_DEFINES_SVH
`define DDS_REGISTER_WORD_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define DDSFMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ddsfmt assertion failed");

// Next-cycle implication, checked only out of reset.
`define DDSFMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ddsfmt assertion failed");

`endif

// ----- hdl/ddsfmt_pkg.sv -----
// Types, codes and constants of the DDS register word formatter.
`timescale 1ns / 1ps
`default_nettype none
package ddsfmt_pkg;

  localparam int DivSteps = 64;

  localparam logic [2:0] ACT_INIT     = 3'd0;
  localparam logic [2:0] ACT_FREQ     = 3'd1;
  localparam logic [2:0] ACT_CODE     = 3'd2;
  localparam logic [2:0] ACT_MV       = 3'd3;
  localparam logic [2:0] ACT_PHASE    = 3'd4;
  localparam logic [2:0] ACT_COMBINED = 3'd5;

  localparam logic [1:0] CFG_REF_CLK  = 2'd0;
  localparam logic [1:0] CFG_PLL_MULT = 2'd1;
  localparam logic [1:0] CFG_MAX_CODE = 2'd2;
  localparam logic [1:0] CFG_FULL_MV  = 2'd3;

  localparam logic [2:0] ADDR_CFR1  = 3'h0;
  localparam logic [2:0] ADDR_CFR2  = 3'h1;
  localparam logic [2:0] ADDR_AMP   = 3'h2;
  localparam logic [2:0] ADDR_FREQ  = 3'h4;
  localparam logic [2:0] ADDR_PHASE = 3'h5;

  localparam logic [31:0] CFR1_WORD    = 32'h0200_0000;
  localparam logic [2:0]  CFR2_LOW     = 3'h7;
  localparam logic [15:0] PHASE_MAX    = 16'h3FFF;
  localparam logic [33:0] SYSCLK_MAX   = 34'd400000000;
  localparam logic [4:0]  PLL_MIN      = 5'd4;
  localparam logic [4:0]  PLL_MAX      = 5'd20;

  localparam logic [28:0] RST_REF_CLK  = 29'd25000000;
  localparam logic [4:0]  RST_PLL_MULT = 5'd16;
  localparam logic [13:0] RST_MAX_CODE = 14'd16383;
  localparam logic [15:0] RST_FULL_MV  = 16'd500;

  typedef enum logic [3:0] {
    OP_INIT1, OP_INIT2, OP_FREQ, OP_FREQC, OP_CODE,
    OP_MV, OP_PHASE, OP_PHASE0, OP_BAD
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] freq;
    logic [15:0] amp;
    logic [15:0] phase;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  register_address;
    logic [31:0] register_data;
    logic [2:0]  byte_count;
    logic        apply_update;
    logic        accepted;
    logic        last;
  } frame_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [33:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [33:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- hdl/ddsfmt_front.sv -----
// Front end: accepts commands, classifies the action, queues them.
`timescale 1ns / 1ps
`default_nettype none
module ddsfmt_front import ddsfmt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_frequency_value,
  input  wire logic [15:0] in_amplitude_value,
  input  wire logic [15:0] in_phase_value,
  output logic             cmd_valid,
  input  wire logic        cmd_ready,
  output cmd_t             cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  op_t        op_cls;

  always_comb begin
    unique case (in_action)
      ACT_INIT:     op_cls = OP_INIT1;
      ACT_FREQ:     op_cls = OP_FREQ;
      ACT_CODE:     op_cls = OP_CODE;
      ACT_MV:       op_cls = OP_MV;
      ACT_PHASE:    op_cls = OP_PHASE;
      ACT_COMBINED: op_cls = OP_PHASE0;
      default:      op_cls = OP_BAD;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op_cls, freq: in_frequency_value,
                         amp: in_amplitude_value, phase: in_phase_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ddsfmt_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ddsfmt_div import ddsfmt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_req_t  req,
  output div_rsp_t  rsp
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [63:0] dvd_r;
  logic [33:0] dvs_r, rem_r;
  logic [34:0] trial;
  logic        ge;
  logic [33:0] rem_nxt;

  assign trial   = {rem_r, dvd_r[63]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? 34'(trial - {1'b0, dvs_r}) : trial[33:0];

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[62:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DivSteps - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done_r, quot: dvd_r, rem: rem_r};

endmodule
`default_nettype wire

// ----- hdl/ddsfmt_back.sv -----
// Back end: configuration registers, frame sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "dds_register_word_formatter_unit_defines.svh"
module ddsfmt_back import ddsfmt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [28:0] cfg_data,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output frame_t           out_frame
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_PLAN = 5'b00100,
    S_DIV  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  localparam frame_t REJECT = '{register_address: 3'h0, register_data: 32'h0,
                                byte_count: 3'd0, apply_update: 1'b0,
                                accepted: 1'b0, last: 1'b1};

  state_t      state_r, state_nxt;
  logic [28:0] ref_r;
  logic [4:0]  pll_r;
  logic [13:0] max_r;
  logic [15:0] fs_r;
  logic [33:0] sysclk_r;
  logic [29:0] prod_r;
  op_t         op_r, op_nxt;
  logic [31:0] f_r;
  logic [15:0] amp_r, ph_r;
  frame_t      frm_r, frm_nxt;
  frame_t      out_frm_r;
  logic        out_valid_r;
  logic        out_load;
  logic [32:0] half;
  logic [34:0] rnd_sum;
  logic        rnd_up;
  logic [30:0] mv_num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= RST_REF_CLK;
      pll_r <= RST_PLL_MULT;
      max_r <= RST_MAX_CODE;
      fs_r  <= RST_FULL_MV;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_CLK:  ref_r <= cfg_data;
        CFG_PLL_MULT: pll_r <= cfg_data[4:0];
        CFG_MAX_CODE: max_r <= cfg_data[13:0];
        CFG_FULL_MV:  fs_r  <= cfg_data[15:0];
      endcase
    end
  end

  // System clock and mV product, each one multiply behind a register.
  always_ff @(posedge clk) begin
    sysclk_r <= 34'(ref_r) * 34'(pll_r);
    prod_r   <= 30'(amp_r) * 30'(max_r);
  end

  assign half    = sysclk_r[33:1];
  assign rnd_sum = {1'b0, div_rsp.rem} + {2'b0, half};
  assign rnd_up  = rnd_sum >= {1'b0, sysclk_r};
  assign mv_num  = {1'b0, prod_r} + {16'b0, fs_r[15:1]};

  assign cmd_ready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    frm_nxt          = frm_r;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = sysclk_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          op_nxt    = cmd.op;
          state_nxt = S_PREP;
        end
      end
      S_PREP: state_nxt = S_PLAN;
      S_PLAN: begin
        state_nxt = S_EMIT;
        frm_nxt   = REJECT;
        unique case (op_r)
          OP_INIT1: begin
            if (!(pll_r < PLL_MIN || pll_r > PLL_MAX || sysclk_r > SYSCLK_MAX)) begin
              frm_nxt = '{ADDR_CFR1, CFR1_WORD, 3'd4, 1'b0, 1'b1, 1'b0};
            end
          end
          OP_INIT2: frm_nxt = '{ADDR_CFR2, {24'b0, pll_r, CFR2_LOW}, 3'd3, 1'b1, 1'b1, 1'b1};
          OP_FREQ, OP_FREQC: begin
            if ({1'b0, f_r} < half) begin
              div_req.start    = 1'b1;
              div_req.dividend = {f_r, 32'b0};
              state_nxt        = S_DIV;
            end
          end
          OP_CODE: begin
            if (amp_r <= {2'b0, max_r}) begin
              frm_nxt = '{ADDR_AMP, {16'b0, amp_r}, 3'd2, 1'b1, 1'b1, 1'b1};
            end
          end
          OP_MV: begin
            if (amp_r <= fs_r) begin
              if (fs_r == 16'd0) begin
                frm_nxt = '{ADDR_AMP, 32'h0, 3'd2, 1'b1, 1'b1, 1'b1};
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = {33'b0, mv_num};
                div_req.divisor  = {18'b0, fs_r};
                state_nxt        = S_DIV;
              end
            end
          end
          OP_PHASE: begin
            if (ph_r <= PHASE_MAX) begin
              frm_nxt = '{ADDR_PHASE, {16'b0, ph_r}, 3'd2, 1'b1, 1'b1, 1'b1};
            end
          end
          OP_PHASE0: frm_nxt = '{ADDR_PHASE, 32'h0, 3'd2, 1'b1, 1'b1, 1'b0};
          default:   frm_nxt = REJECT;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_EMIT;
          if (op_r == OP_MV) begin
            frm_nxt = '{ADDR_AMP, {18'b0, div_rsp.quot[13:0]}, 3'd2, 1'b1, 1'b1, 1'b1};
          end else begin
            frm_nxt = '{ADDR_FREQ, 32'(div_rsp.quot[31:0] + {31'b0, rnd_up}),
                        3'd4, 1'b1, 1'b1, (op_r == OP_FREQ)};
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (frm_r.last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_PLAN;
            unique case (op_r)
              OP_INIT1:  op_nxt = OP_INIT2;
              OP_PHASE0: op_nxt = OP_FREQC;
              OP_FREQC:  op_nxt = OP_MV;
              default:   op_nxt = OP_BAD;
            endcase
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid) begin
      f_r   <= cmd.freq;
      amp_r <= cmd.amp;
      ph_r  <= cmd.phase;
    end
    op_r  <= op_nxt;
    frm_r <= frm_nxt;
    if (out_load) out_frm_r <= frm_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_frame = out_frm_r;

  `DDSFMT_ASSERT_IMP(a_reject_is_last, out_valid_r && !out_frm_r.accepted, out_frm_r.last)
  `DDSFMT_ASSERT_IMP(a_frame_has_bytes, out_valid_r && out_frm_r.accepted, out_frm_r.byte_count != 3'd0)
  `DDSFMT_ASSERT_NXT(a_div_start_waits, div_req.start, state_r == S_DIV)

endmodule
`default_nettype wire

// ----- hdl/dds_register_word_formatter_unit.sv -----
// Path: a request leaves the queue only while the back end is idle, then passes the
// prepare and plan states to the emit state and the output register; a tuning word or
// mV scaling first runs a 64-step divide in the shared radix-2 divider. Each further
// frame of a request returns from emit to plan. No new request is taken until the last
// frame is loaded; a 2-entry queue buffers requests.
// Reset: synchronous, active low; config registers return to defaults, queue empties.
`timescale 1ns / 1ps
`default_nettype none
module dds_register_word_formatter_unit import ddsfmt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [28:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_frequency_value,
  input  wire logic [15:0] in_amplitude_value,
  input  wire logic [15:0] in_phase_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_register_address,
  output logic [31:0]      out_register_data,
  output logic [2:0]       out_byte_count,
  output logic             out_apply_update,
  output logic             out_accepted,
  output logic             out_last
);

  logic     cmd_valid, cmd_ready;
  cmd_t     cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;
  frame_t   out_frame;

  ddsfmt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_action, .in_frequency_value,
    .in_amplitude_value, .in_phase_value, .cmd_valid, .cmd_ready, .cmd
  );

  ddsfmt_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  ddsfmt_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .cmd_valid, .cmd_ready, .cmd,
    .div_req, .div_rsp, .out_valid, .out_ready, .out_frame
  );

  assign out_register_address = out_frame.register_address;
  assign out_register_data    = out_frame.register_data;
  assign out_byte_count       = out_frame.byte_count;
  assign out_apply_update     = out_frame.apply_update;
  assign out_accepted         = out_frame.accepted;
  assign out_last             = out_frame.last;

endmodule
`default_nettype wire

// ----- test/dds_frame_checker.sv -----
// Frame predictor and scoreboard for the DDS register word formatter.
`timescale 1ns / 1ps
module dds_frame_checker import ddsfmt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [28:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_frequency_value,
  input  wire logic [15:0] in_amplitude_value,
  input  wire logic [15:0] in_phase_value,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  out_register_address,
  input  wire logic [31:0] out_register_data,
  input  wire logic [2:0]  out_byte_count,
  input  wire logic        out_apply_update,
  input  wire logic        out_accepted,
  input  wire logic        out_last,
  output int               fail_count,
  output int               frames_pending,
  output int               frames_seen
);

  logic [28:0] ref_clk_hz;
  logic [4:0]  pll_mult;
  logic [13:0] max_code;
  logic [15:0] full_mv;
  frame_t      frame_queue[$];

  function automatic frame_t reject_frame();
    frame_t f;
    f = '0;
    f.last = 1'b1;
    return f;
  endfunction

  function automatic frame_t make_frame(logic [2:0] a, logic [31:0] d, logic [2:0] n,
                                        logic upd, logic lst);
    frame_t f;
    f.register_address = a;
    f.register_data = d;
    f.byte_count = n;
    f.apply_update = upd;
    f.accepted = 1'b1;
    f.last = lst;
    return f;
  endfunction

  // Push a tuning-word frame or a marker; returns 1 when accepted.
  function automatic bit push_tuning_word(logic [31:0] fr, logic lst);
    logic [63:0] sys, half, num, q, r;
    sys = 64'(ref_clk_hz) * 64'(pll_mult);
    half = sys >> 1;
    if (64'(fr) >= half) begin
      frame_queue.push_back(reject_frame());
      return 0;
    end
    num = {fr, 32'h0};
    q = num / sys;
    r = num % sys;
    if (r + half >= sys) q = q + 1;
    frame_queue.push_back(make_frame(ADDR_FREQ, q[31:0], 3'd4, 1'b1, lst));
    return 1;
  endfunction

  function automatic void push_amp_code(logic [63:0] code);
    if (code > 64'(max_code)) frame_queue.push_back(reject_frame());
    else frame_queue.push_back(make_frame(ADDR_AMP, code[31:0], 3'd2, 1'b1, 1'b1));
  endfunction

  function automatic void push_amp_mv(logic [15:0] mv);
    logic [63:0] code;
    if (mv > full_mv) begin
      frame_queue.push_back(reject_frame());
      return;
    end
    if (full_mv == 0) code = 0;
    else code = (64'(mv) * 64'(max_code) + 64'(full_mv >> 1)) / 64'(full_mv);
    push_amp_code(code);
  endfunction

  function automatic void predict_frames(logic [2:0] act, logic [31:0] fr,
                                         logic [15:0] amp, logic [15:0] ph);
    logic [63:0] sys;
    sys = 64'(ref_clk_hz) * 64'(pll_mult);
    case (act)
      ACT_INIT: begin
        if (pll_mult < PLL_MIN || pll_mult > PLL_MAX || sys > 64'(SYSCLK_MAX))
          frame_queue.push_back(reject_frame());
        else begin
          frame_queue.push_back(make_frame(ADDR_CFR1, CFR1_WORD, 3'd4, 1'b0, 1'b0));
          frame_queue.push_back(make_frame(ADDR_CFR2, {24'h0, pll_mult, CFR2_LOW},
                                           3'd3, 1'b1, 1'b1));
        end
      end
      ACT_FREQ: void'(push_tuning_word(fr, 1'b1));
      ACT_CODE: push_amp_code(64'(amp));
      ACT_MV: push_amp_mv(amp);
      ACT_PHASE: begin
        if (ph > PHASE_MAX) frame_queue.push_back(reject_frame());
        else frame_queue.push_back(make_frame(ADDR_PHASE, {16'h0, ph}, 3'd2, 1'b1, 1'b1));
      end
      ACT_COMBINED: begin
        frame_queue.push_back(make_frame(ADDR_PHASE, 32'h0, 3'd2, 1'b1, 1'b0));
        if (push_tuning_word(fr, 1'b0)) push_amp_mv(amp);
      end
      default: frame_queue.push_back(reject_frame());
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign frames_pending = frame_queue.size();

  always @(posedge clk) begin
    frame_t w;
    if (!rst_n) begin
      ref_clk_hz <= RST_REF_CLK;
      pll_mult <= RST_PLL_MULT;
      max_code <= RST_MAX_CODE;
      full_mv <= RST_FULL_MV;
      frame_queue.delete();
      fail_count = 0;
      frames_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        frames_seen++;
        if (frame_queue.size() == 0) begin
          report_mismatch("unexpected frame", out_register_data, 32'h0);
        end else begin
          w = frame_queue.pop_front();
          if (out_register_address !== w.register_address)
            report_mismatch("address", 32'(out_register_address), 32'(w.register_address));
          if (out_register_data !== w.register_data)
            report_mismatch("data", out_register_data, w.register_data);
          if (out_byte_count !== w.byte_count)
            report_mismatch("byte_count", 32'(out_byte_count), 32'(w.byte_count));
          if (out_apply_update !== w.apply_update)
            report_mismatch("apply_update", 32'(out_apply_update), 32'(w.apply_update));
          if (out_accepted !== w.accepted)
            report_mismatch("accepted", 32'(out_accepted), 32'(w.accepted));
          if (out_last !== w.last)
            report_mismatch("last", 32'(out_last), 32'(w.last));
        end
      end
      if (in_valid && in_ready)
        predict_frames(in_action, in_frequency_value, in_amplitude_value, in_phase_value);
      if (cfg_we) begin
        case (cfg_index)
          CFG_REF_CLK:  ref_clk_hz <= cfg_data;
          CFG_PLL_MULT: pll_mult <= cfg_data[4:0];
          CFG_MAX_CODE: max_code <= cfg_data[13:0];
          CFG_FULL_MV:  full_mv <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- test/tb_dds_register_word_formatter_unit.sv -----
// Top of the DDS register word formatter testbench: stimulus, config phases, verdict.
`timescale 1ns / 1ps
module tb_dds_register_word_formatter_unit import ddsfmt_pkg::*;;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_REF_CLK;
  logic [28:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_action = ACT_INIT;
  logic [31:0] in_frequency_value = '0;
  logic [15:0] in_amplitude_value = '0;
  logic [15:0] in_phase_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_register_address;
  logic [31:0] out_register_data;
  logic [2:0]  out_byte_count;
  logic        out_apply_update;
  logic        out_accepted;
  logic        out_last;
  int          fail_count, frames_pending, frames_seen;
  int          requests_sent = 0;
  bit          quiet_mode = 0;
  bit          long_hold = 0;

  dds_register_word_formatter_unit dut (.*);
  dds_frame_checker checker_u (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic write_reg(logic [1:0] idx, logic [28:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Keep valid high between back-to-back requests; drop it only for an idle gap.
  task automatic send_request(logic [2:0] act, logic [31:0] fr, logic [15:0] amp,
                              logic [15:0] ph);
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_frequency_value <= fr;
    in_amplitude_value <= amp;
    in_phase_value <= ph;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Drain all predicted frames, then let the divider settle before touching config.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frames_pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_request();
    logic [2:0]  act;
    logic [31:0] fr;
    logic [15:0] amp, ph;
    act = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) act = 3'($urandom_range(6, 7));
    else if (act > ACT_COMBINED) act = ACT_COMBINED;
    fr = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 220000000);
    amp = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 600));
    ph = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 16383));
    send_request(act, fr, amp, ph);
  endtask

  // Receiver: random stall bursts, one long hold-off, none when quiet.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: defaults
    send_request(ACT_INIT, 0, 0, 0);
    send_request(ACT_FREQ, 0, 0, 0);
    send_request(ACT_FREQ, 199999999, 0, 0);
    send_request(ACT_FREQ, 200000000, 0, 0);
    send_request(ACT_FREQ, 32'hFFFF_FFFF, 0, 0);
    send_request(ACT_CODE, 0, 16383, 0);
    send_request(ACT_CODE, 0, 16384, 0);
    send_request(ACT_CODE, 0, 16'hFFFF, 0);
    send_request(ACT_MV, 0, 500, 0);
    send_request(ACT_MV, 0, 501, 0);
    send_request(ACT_MV, 0, 0, 0);
    send_request(ACT_PHASE, 0, 0, 16'h3FFF);
    send_request(ACT_PHASE, 0, 0, 16'h4000);
    send_request(ACT_PHASE, 0, 0, 16'hFFFF);
    send_request(ACT_COMBINED, 1000000, 250, 16'hFFFF);
    send_request(ACT_COMBINED, 300000000, 250, 0);
    send_request(ACT_COMBINED, 1000000, 600, 0);
    send_request(3'd6, 0, 0, 0);
    send_request(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    wait_idle();
    // zero sysclk, zero full scale, zero max code
    write_reg(CFG_PLL_MULT, 0);
    write_reg(CFG_FULL_MV, 0);
    write_reg(CFG_MAX_CODE, 0);
    send_request(ACT_INIT, 0, 0, 0);
    send_request(ACT_FREQ, 0, 0, 0);
    send_request(ACT_MV, 0, 0, 0);
    send_request(ACT_MV, 0, 1, 0);
    send_request(ACT_CODE, 0, 1, 0);
    wait_idle();
    // pressure: long receiver hold-off while requests keep coming
    write_reg(CFG_PLL_MULT, 5'd20);
    write_reg(CFG_REF_CLK, 29'd20000000);
    write_reg(CFG_MAX_CODE, 14'h3FFF);
    write_reg(CFG_FULL_MV, 16'hFFFF);
    long_hold = 1;
    repeat (12) random_request();
    wait_idle();
    for (int phase_i = 0; phase_i < 5; phase_i++) begin
      case (phase_i)
        0: begin
          write_reg(CFG_REF_CLK, 29'h1FFF_FFFF);
          write_reg(CFG_PLL_MULT, 5'd31);
        end
        1: begin
          write_reg(CFG_REF_CLK, 29'd1);
          write_reg(CFG_PLL_MULT, 5'd4);
          write_reg(CFG_FULL_MV, 16'd1);
        end
        2: begin
          write_reg(CFG_REF_CLK, 29'd400000000);
          write_reg(CFG_PLL_MULT, 5'd1);
          write_reg(CFG_MAX_CODE, 14'd1000);
        end
        3: begin
          write_reg(CFG_REF_CLK, 29'($urandom_range(1, 400000000)));
          write_reg(CFG_PLL_MULT, 5'($urandom_range(0, 31)));
          write_reg(CFG_MAX_CODE, 14'($urandom()));
          write_reg(CFG_FULL_MV, 16'($urandom_range(1, 65535)));
        end
        default: begin
          write_reg(CFG_REF_CLK, 29'd25000000);
          write_reg(CFG_PLL_MULT, 5'd16);
          write_reg(CFG_MAX_CODE, 14'd16383);
          write_reg(CFG_FULL_MV, 16'd500);
          quiet_mode = 1;
        end
      endcase
      repeat (29) random_request();
      wait_idle();
    end
    $display("Covered %0d requests and %0d frames over eight register settings,",
             requests_sent, frames_seen);
    $display("including zero system clock, zero full scale and a long output stall.");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ddsfmt_pkg.sv
hdl/ddsfmt_front.sv
hdl/ddsfmt_div.sv
hdl/ddsfmt_back.sv
hdl/dds_register_word_formatter_unit.sv
test/dds_frame_checker.sv
test/tb_dds_register_word_formatter_unit.sv
